// File: rtl/xlrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xlrg_pkg
// Shared types and constants of the xorshift / congruential random generator.
// ----------------------------------------------------------------------------
package xlrg_pkg;

   localparam int WORD_W      = 64;
   localparam int SHIFT_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int OP_W        = 2;

   // multiplier: one 64 x 16 partial product per cycle
   localparam int MUL_CHUNK   = 16;
   localparam int MUL_STEPS   = WORD_W / MUL_CHUNK;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

   // reducer: one remainder bit per cycle
   localparam int DIV_CNT_W   = $clog2(WORD_W);

   typedef enum logic [OP_W-1:0] {
      OP_RESEED   = 2'd0,
      OP_XORSHIFT = 2'd1,
      OP_LCG      = 2'd2,
      OP_XS_LCG   = 2'd3
   } op_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_THIRD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MULTIPLIER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS      = 3'd5;

   localparam logic [SHIFT_W-1:0] SHIFT_FIRST_RST  = 6'd13;
   localparam logic [SHIFT_W-1:0] SHIFT_SECOND_RST = 6'd7;
   localparam logic [SHIFT_W-1:0] SHIFT_THIRD_RST  = 6'd17;
   localparam logic [WORD_W-1:0]  MULTIPLIER_RST   = 64'd6364136223846793005;
   localparam logic [WORD_W-1:0]  INCREMENT_RST    = 64'd1442695040888963407;
   localparam logic [WORD_W-1:0]  MODULUS_RST      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0]  SEED_RST         = 64'd88172645463325252;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

// File: rtl/xorshift_lcg_random_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift_lcg_random_generator
// 64-bit generator value with reseed, xorshift and congruential steps.
//
// req_ channel: one item carries an operation and a seed; every item yields
// exactly one rsp_ item holding the generator value after the operation.
// csr_ channel: register writes (shifts, multiplier, increment, modulus),
// always ready; write only while no item is in flight.
// Path from request to response:
//   reseed                      result taken straight from the seed
//   xorshift                    the shift stages, one shift stage per cycle
//   congruential                the 64 x 16 iterative multiplier, then the
//                               bit-serial remainder unit; the remainder
//                               unit is skipped when the modulus is zero
//   xorshift then congruential  the xorshift stages first, then congruential
// One item is in work at a time: reseeds can follow one per cycle while
// responses are taken, any other item holds off the input until its result
// is produced. A stalled response holds the result register and blocks further
// requests. Reset loads the register defaults and the default seed.
// ----------------------------------------------------------------------------
module xorshift_lcg_random_generator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [xlrg_pkg::OP_W-1:0]        req_operation,
   input  wire logic [xlrg_pkg::WORD_W-1:0]      req_seed_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [xlrg_pkg::WORD_W-1:0]      rsp_random_value,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [xlrg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [xlrg_pkg::WORD_W-1:0]      csr_wdata
);
   import xlrg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_XS   = 4'b0010,
      S_MUL  = 4'b0100,
      S_DIV  = 4'b1000
   } state_type;

   localparam logic [1:0] XS_FIRST  = 2'd0;
   localparam logic [1:0] XS_SECOND = 2'd1;
   localparam logic [1:0] XS_THIRD  = 2'd2;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [1:0]        xs_cnt_ff, xs_cnt_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic              mul_start_ff, mul_start_in;
   logic              div_start_ff, div_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff;

   logic [SHIFT_W-1:0] shift_first_ff, shift_second_ff, shift_third_ff;
   logic [WORD_W-1:0]  multiplier_ff, increment_ff, modulus_ff;

   logic              req_accept;
   logic              csr_accept;
   logic              finish;
   logic [WORD_W-1:0] result;
   logic [WORD_W-1:0] xs_out;
   logic [WORD_W-1:0] mul_product;
   logic [WORD_W-1:0] div_rem;
   unit_sts_type      mul_sts;
   unit_sts_type      div_sts;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   // shared shift-and-xor unit, one xorshift stage per cycle
   always_comb begin
      case (xs_cnt_ff)
         XS_FIRST:  xs_out = value_ff ^ (value_ff << shift_first_ff);
         XS_SECOND: xs_out = value_ff ^ (value_ff >> shift_second_ff);
         default:   xs_out = value_ff ^ (value_ff << shift_third_ff);
      endcase
   end

   xlrg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .operand (value_ff),
      .mult    (multiplier_ff),
      .addend  (increment_ff),
      .sts     (mul_sts),
      .product (mul_product)
   );

   xlrg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (mul_product),
      .divisor   (modulus_ff),
      .sts       (div_sts),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      xs_cnt_in    = xs_cnt_ff;
      value_in     = value_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      finish       = 1'b0;
      result       = value_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in = op_type'(req_operation);
               case (op_type'(req_operation))
                  OP_RESEED: begin
                     finish = 1'b1;
                     result = req_seed_value;
                  end
                  OP_LCG: begin
                     state_in     = S_MUL;
                     mul_start_in = 1'b1;
                  end
                  default: begin
                     state_in  = S_XS;
                     xs_cnt_in = XS_FIRST;
                  end
               endcase
            end
         end
         S_XS: begin
            value_in  = xs_out;
            xs_cnt_in = xs_cnt_ff + 1'b1;
            if (xs_cnt_ff == XS_THIRD) begin
               if (op_ff == OP_XORSHIFT) begin
                  finish   = 1'b1;
                  result   = xs_out;
                  state_in = S_IDLE;
               end else begin
                  state_in     = S_MUL;
                  mul_start_in = 1'b1;
               end
            end
         end
         S_MUL: begin
            if (mul_sts.done) begin
               if (modulus_ff != '0) begin
                  state_in     = S_DIV;
                  div_start_in = 1'b1;
               end else begin
                  finish   = 1'b1;
                  result   = mul_product;
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               finish   = 1'b1;
               result   = div_rem;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (finish) begin
         value_in = result;
      end
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_RESEED;
         xs_cnt_ff    <= XS_FIRST;
         value_ff     <= SEED_RST;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         xs_cnt_ff    <= xs_cnt_in;
         value_ff     <= value_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_first_ff  <= SHIFT_FIRST_RST;
         shift_second_ff <= SHIFT_SECOND_RST;
         shift_third_ff  <= SHIFT_THIRD_RST;
         multiplier_ff   <= MULTIPLIER_RST;
         increment_ff    <= INCREMENT_RST;
         modulus_ff      <= MODULUS_RST;
      end else if (csr_accept) begin
         case (csr_index)
            CSR_SHIFT_FIRST:  shift_first_ff  <= csr_wdata[SHIFT_W-1:0];
            CSR_SHIFT_SECOND: shift_second_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_SHIFT_THIRD:  shift_third_ff  <= csr_wdata[SHIFT_W-1:0];
            CSR_MULTIPLIER:   multiplier_ff   <= csr_wdata;
            CSR_INCREMENT:    increment_ff    <= csr_wdata;
            CSR_MODULUS:      modulus_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_data_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.busy && div_sts.busy))
      else $error("multiplier and remainder unit busy together");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == S_MUL))
      else $error("multiplier finished outside its state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_DIV))
      else $error("remainder unit finished outside its state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites a pending response");

endmodule
`default_nettype wire

// File: rtl/xlrg_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xlrg_mul
// Iterative multiply-add: (a * b + c) mod 2^64, 16 bits of b per cycle.
// ----------------------------------------------------------------------------
module xlrg_mul (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [xlrg_pkg::WORD_W-1:0] operand,
   input  wire logic [xlrg_pkg::WORD_W-1:0] mult,
   input  wire logic [xlrg_pkg::WORD_W-1:0] addend,
   output xlrg_pkg::unit_sts_type           sts,
   output logic      [xlrg_pkg::WORD_W-1:0] product
);
   import xlrg_pkg::*;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [MUL_CNT_W-1:0]          cnt_ff, cnt_in;
   logic [WORD_W-1:0]             acc_ff, acc_in;
   logic [WORD_W-1:0]             vs_ff, vs_in;
   logic [WORD_W-1:0]             mc_ff, mc_in;
   logic [WORD_W+MUL_CHUNK-1:0]   pp;
   logic                          last;

   assign pp   = vs_ff * mc_ff[MUL_CHUNK-1:0];
   assign last = (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      vs_in   = vs_ff;
      mc_in   = mc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = addend;
         vs_in   = operand;
         mc_in   = mult;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp[WORD_W-1:0];
         vs_in  = vs_ff << MUL_CHUNK;
         mc_in  = mc_ff >> MUL_CHUNK;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      vs_ff  <= vs_in;
      mc_ff  <= mc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule
`default_nettype wire

// File: rtl/xlrg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xlrg_div
// Restoring remainder unit: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module xlrg_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [xlrg_pkg::WORD_W-1:0] dividend,
   input  wire logic [xlrg_pkg::WORD_W-1:0] divisor,
   output xlrg_pkg::unit_sts_type           sts,
   output logic      [xlrg_pkg::WORD_W-1:0] remainder
);
   import xlrg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    num_ff, num_in;
   logic [WORD_W-1:0]    den_ff, den_in;
   logic [WORD_W:0]      rs;
   logic [WORD_W:0]      diff;

   assign rs   = {rem_ff, num_ff[WORD_W-1]};
   assign diff = rs - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[WORD_W] ? rs[WORD_W-1:0] : diff[WORD_W-1:0];
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire
